### rtl/assert_macros.svh
// Assertion macros used by the top level of the NTC thermistor linearizer.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define NTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define NTL_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

### rtl/ntl_pkg.sv
// Package of the NTC thermistor linearizer: widths, resistance table, types.
// No dependencies.
package ntl_pkg;
  localparam int ADC_BITS = 12;
  localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};
  localparam int R1_W = 17;
  localparam int RES_W = 24;
  localparam int TEMP_W = 15;
  localparam int TABLE_POINTS = 37;
  localparam int IDX_W = 6;
  localparam int PROD_W = R1_W + ADC_BITS;
  localparam int NUM1_W = PROD_W + 4;
  localparam int NUM2_W = RES_W + 9;
  localparam int DIV_NUM_W = (NUM1_W > NUM2_W) ? NUM1_W : NUM2_W;
  localparam int DIV_DEN_W = RES_W;
  localparam int PADDR_W = 3;
  localparam logic [R1_W-1:0] R1_RESET = 17'd10000;
  localparam logic [RES_W-1:0] RES_SAT = {RES_W{1'b1}};
  localparam logic [TEMP_W-1:0] TEMP_FIRST = 15'h7FFF - 15'd5499; // -5500
  localparam logic [TEMP_W-1:0] TEMP_LAST = 15'd12500;
  localparam logic [0:0] REG_SERIES = 1'b0;

  localparam logic [RES_W-1:0] RES_TABLE [TABLE_POINTS] = '{
    24'd12146000, 24'd8443900, 24'd5924300, 24'd4193800, 24'd2994800,
    24'd2156700, 24'd1564100, 24'd1146600, 24'd845100, 24'd629270,
    24'd470770, 24'd355630, 24'd271190, 24'd208600, 24'd162040,
    24'd126830, 24'd100000, 24'd79420, 24'd63270, 24'd50740,
    24'd41030, 24'd33360, 24'd27240, 24'd22370, 24'd18460,
    24'd15300, 24'd12750, 24'd10680, 24'd8993, 24'd7607,
    24'd6452, 24'd5494, 24'd4700, 24'd4036, 24'd3474,
    24'd3001, 24'd2601
  };

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic [IDX_W-1:0] idx;
    logic             below;
    logic             above;
  } side_t;
endpackage

### rtl/ntc_thermistor_linearizer.sv
// Top level of the NTC thermistor linearizer: register port and pipeline.
// Depends on ntl_pkg, ntl_div, ntl_interp and assert_macros.svh.
//
// The block turns one converter sample of a divider (fixed series resistor
// above an NTC 10k thermistor) into the thermistor resistance in tenths of
// an ohm and the temperature in hundredths of a degree Celsius, interpolated
// in a 37-point table from -55 C to 125 C. It is a pipeline: busy is
// never raised, so an item may be started in every clock cycle, and each
// item's result appears on the out_ ports with out_valid high for one
// cycle. The pipeline holds the two bit-per-stage dividers (33 stages
// each: the resistance quotient and the interpolation offset), plus seven
// stages for the multiply, round, saturate, table compare, encode, scale
// and final formatting. The receiver cannot stall, so nothing is ever held
// back. Resistances above the -55 C entry (including a full-scale code,
// whose resistance saturates) give -5500 with below_range
// set; resistances at or below the 125 C entry (including code zero) give
// 12500 with above_range set. The series resistor register sits at byte
// address 0 and should be written only while no item is in flight.
module ntc_thermistor_linearizer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ntl_pkg::ADC_BITS-1:0]     in_adc_code,
  output logic                             out_valid,
  output logic signed [ntl_pkg::TEMP_W-1:0] out_temperature_centi,
  output logic [ntl_pkg::RES_W-1:0]        out_resistance_tenths,
  output logic                             out_below_range,
  output logic                             out_above_range,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ntl_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import ntl_pkg::*;
  `include "assert_macros.svh"

  logic [R1_W-1:0] series_r;

  // Register port: one register, decoded on the word address bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r <= R1_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SERIES)) begin
      series_r <= pwdata[R1_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SERIES) ? {{(32 - R1_W){1'b0}}, series_r} : '0;
  assign busy   = 1'b0;

  // Stage 1: series resistor times code, and the divisor ADC_MAX - code.
  logic                p1_vld_r;
  logic [PROD_W-1:0]   p1_prod_r;
  logic [ADC_BITS-1:0] p1_d_r;

  // Stage 2: times ten plus half the divisor, for round to nearest.
  logic                 p2_vld_r;
  logic [DIV_NUM_W-1:0] p2_num_r;
  logic [DIV_DEN_W-1:0] p2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= start && !busy;
      p2_vld_r <= p1_vld_r;
    end
    p1_prod_r <= PROD_W'(series_r) * PROD_W'(in_adc_code);
    p1_d_r    <= ADC_MAX - in_adc_code;
    p2_num_r  <= DIV_NUM_W'({p1_prod_r, 3'b000}) + DIV_NUM_W'({p1_prod_r, 1'b0})
                 + DIV_NUM_W'(p1_d_r >> 1);
    p2_den_r  <= DIV_DEN_W'(p1_d_r);
  end

  // A zero divisor yields an all-ones quotient, which saturates below.
  logic                 d1_vld;
  logic [DIV_NUM_W-1:0] d1_quo;

  ntl_div u_res_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (p2_vld_r),
    .num_i  (p2_num_r),
    .den_i  (p2_den_r),
    .side_i ('0),
    .vld_o  (d1_vld),
    .quo_o  (d1_quo),
    .side_o ()
  );

  // Stage 3: saturate the resistance to its output width.
  logic             p3_vld_r;
  logic [RES_W-1:0] p3_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= d1_vld;
    end
    p3_res_r <= (|d1_quo[DIV_NUM_W-1:RES_W]) ? RES_SAT : d1_quo[RES_W-1:0];
  end

  logic                 ip_vld;
  logic [DIV_NUM_W-1:0] ip_num;
  logic [DIV_DEN_W-1:0] ip_den;
  side_t                ip_side;

  ntl_interp u_interp (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (p3_vld_r),
    .res_i  (p3_res_r),
    .vld_o  (ip_vld),
    .num_o  (ip_num),
    .den_o  (ip_den),
    .side_o (ip_side)
  );

  logic                 d2_vld;
  logic [DIV_NUM_W-1:0] d2_quo;
  side_t                d2_side;

  ntl_div u_off_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (ip_vld),
    .num_i  (ip_num),
    .den_i  (ip_den),
    .side_i (ip_side),
    .vld_o  (d2_vld),
    .quo_o  (d2_quo),
    .side_o (d2_side)
  );

  // Final stage: temperature of entry idx minus the offset, or a clamp.
  logic [15:0]       scaled;
  logic [TEMP_W-1:0] temp_nxt;
  logic              out_vld_r;
  logic [TEMP_W-1:0] out_temp_r;
  logic [RES_W-1:0]  out_res_r;
  logic              out_below_r;
  logic              out_above_r;

  always_comb begin
    scaled = 16'(d2_side.idx) * 16'd500;
    if (d2_side.below) begin
      temp_nxt = TEMP_FIRST;
    end else if (d2_side.above) begin
      temp_nxt = TEMP_LAST;
    end else begin
      temp_nxt = TEMP_FIRST + scaled[TEMP_W-1:0] - TEMP_W'(d2_quo[8:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= d2_vld;
    end
    out_temp_r  <= temp_nxt;
    out_res_r   <= d2_side.res;
    out_below_r <= d2_side.below;
    out_above_r <= d2_side.above;
  end

  assign out_valid             = out_vld_r;
  assign out_temperature_centi = out_temp_r;
  assign out_resistance_tenths = out_res_r;
  assign out_below_range       = out_below_r;
  assign out_above_range       = out_above_r;

  `NTL_ASSERT_NEVER(a_flags_excl, clk, rst_n, out_vld_r && out_below_r && out_above_r)
  `NTL_ASSERT_IMP(a_below_clamp, clk, rst_n, out_vld_r && out_below_r, out_temp_r == TEMP_FIRST)
  `NTL_ASSERT_IMP(a_above_clamp, clk, rst_n, out_vld_r && out_above_r, out_temp_r == TEMP_LAST)
  `NTL_ASSERT_IMP(a_sat_cold, clk, rst_n, out_vld_r && (out_res_r == RES_SAT), out_below_r)
endmodule

### rtl/ntl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on ntl_pkg.
module ntl_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           vld_i,
  input  logic [ntl_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [ntl_pkg::DIV_DEN_W-1:0]  den_i,
  input  ntl_pkg::side_t                 side_i,
  output logic                           vld_o,
  output logic [ntl_pkg::DIV_NUM_W-1:0]  quo_o,
  output ntl_pkg::side_t                 side_o
);
  import ntl_pkg::*;

  logic                 vld_r  [DIV_NUM_W];
  logic [DIV_NUM_W-1:0] num_r  [DIV_NUM_W];
  logic [DIV_NUM_W-1:0] quo_r  [DIV_NUM_W];
  logic [DIV_DEN_W-1:0] rem_r  [DIV_NUM_W];
  logic [DIV_DEN_W-1:0] den_r  [DIV_NUM_W];
  side_t                side_r [DIV_NUM_W];

  for (genvar s = 0; s < DIV_NUM_W; s++) begin : g_stage
    logic                 v_in;
    logic [DIV_NUM_W-1:0] n_in;
    logic [DIV_NUM_W-1:0] q_in;
    logic [DIV_DEN_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    side_t                sd_in;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    if (s == 0) begin : g_first
      assign v_in   = vld_i;
      assign n_in   = num_i;
      assign q_in   = '0;
      assign rem_in = '0;
      assign den_in = den_i;
      assign sd_in  = side_i;
    end else begin : g_next
      assign v_in   = vld_r[s-1];
      assign n_in   = num_r[s-1];
      assign q_in   = quo_r[s-1];
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign sd_in  = side_r[s-1];
    end

    assign trial = {rem_in, n_in[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= v_in;
      end
      num_r[s]  <= {n_in[DIV_NUM_W-2:0], 1'b0};
      quo_r[s]  <= {q_in[DIV_NUM_W-2:0], ge};
      rem_r[s]  <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      den_r[s]  <= den_in;
      side_r[s] <= sd_in;
    end
  end

  assign vld_o  = vld_r[DIV_NUM_W-1];
  assign quo_o  = quo_r[DIV_NUM_W-1];
  assign side_o = side_r[DIV_NUM_W-1];
endmodule

### rtl/ntl_interp.sv
// Table search and interpolation numerator: compare, encode, scale stages.
// Depends on ntl_pkg.
module ntl_interp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           vld_i,
  input  logic [ntl_pkg::RES_W-1:0]      res_i,
  output logic                           vld_o,
  output logic [ntl_pkg::DIV_NUM_W-1:0]  num_o,
  output logic [ntl_pkg::DIV_DEN_W-1:0]  den_o,
  output ntl_pkg::side_t                 side_o
);
  import ntl_pkg::*;

  logic                    a_vld_r;
  logic [TABLE_POINTS-1:0] a_gt_r;
  logic [RES_W-1:0]        a_res_r;
  logic                    b_vld_r;
  logic [RES_W-1:0]        b_diff_r;
  logic [RES_W-1:0]        b_den_r;
  side_t                   b_side_r;
  logic                    c_vld_r;
  logic [DIV_NUM_W-1:0]    c_num_r;
  logic [DIV_DEN_W-1:0]    c_den_r;
  side_t                   c_side_r;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] sel;
  logic             below;
  logic             above;
  logic [RES_W-1:0] diff_nxt;
  logic [RES_W-1:0] den_nxt;

  // First entry that lies below the resistance; TABLE_POINTS when none does.
  always_comb begin
    idx = IDX_W'(TABLE_POINTS);
    for (int i = TABLE_POINTS - 1; i >= 0; i--) begin
      if (a_gt_r[i]) begin
        idx = IDX_W'(i);
      end
    end
    below = (idx == '0);
    above = (idx == IDX_W'(TABLE_POINTS));
    sel   = (below || above) ? IDX_W'(1) : idx;
    if (below || above) begin
      diff_nxt = '0;
      den_nxt  = RES_W'(1);
    end else begin
      diff_nxt = a_res_r - RES_TABLE[sel];
      den_nxt  = RES_TABLE[sel - IDX_W'(1)] - RES_TABLE[sel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= vld_i;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
    for (int i = 0; i < TABLE_POINTS; i++) begin
      a_gt_r[i] <= (res_i > RES_TABLE[i]);
    end
    a_res_r        <= res_i;
    b_diff_r       <= diff_nxt;
    b_den_r        <= den_nxt;
    b_side_r.res   <= a_res_r;
    b_side_r.idx   <= idx;
    b_side_r.below <= below;
    b_side_r.above <= above;
    c_num_r        <= DIV_NUM_W'(b_diff_r) * DIV_NUM_W'(500)
                      + DIV_NUM_W'(b_den_r >> 1);
    c_den_r        <= b_den_r;
    c_side_r       <= b_side_r;
  end

  assign vld_o  = c_vld_r;
  assign num_o  = c_num_r;
  assign den_o  = c_den_r;
  assign side_o = c_side_r;
endmodule
